[hdl/lli_pkg.sv]
package lli_pkg;

    localparam int COORD_W = 32;                  // Q16.16 coordinate
    localparam int DIFF_W  = COORD_W + 1;         // point difference
    localparam int PROD_W  = 2 * COORD_W;         // coordinate product
    localparam int CROSS_W = PROD_W + 1;          // cross product PA, PB
    localparam int DPROD_W = 2 * DIFF_W;          // difference product
    localparam int DET_W   = DPROD_W + 1;         // determinant
    localparam int HALF_W  = 32;                  // split point of PA, PB
    localparam int NUM_W   = DET_W + HALF_W;      // numerator
    localparam int QUOT_W  = 32;                  // quotient bits produced

    localparam int GEOM_LAT = 6;                  // register stages of the front end
    localparam int DIV_LAT  = QUOT_W + 1;         // range check plus one stage a bit
    localparam int PIPE_LAT = GEOM_LAT + DIV_LAT;

    typedef logic signed [COORD_W-1:0] t_coord;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_end_x;
        t_coord a_end_y;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_end_x;
        t_coord b_end_y;
    } t_in_item;

    typedef struct packed {
        t_coord cross_x;
        t_coord cross_y;
        logic   no_crossing;
        logic   clipped;
    } t_out_item;

    // Front end to divider: magnitudes and quotient signs
    typedef struct packed {
        logic [NUM_W-1:0] mag_x;
        logic [NUM_W-1:0] mag_y;
        logic [DET_W-1:0] den;
        logic             neg_x;
        logic             neg_y;
        logic             zero;
    } t_geom;

endpackage

[hdl/lli_if.sv]
interface lli_in_if;
    logic               valid;
    logic               ready;
    lli_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lli_out_if;
    logic               valid;
    logic               ready;
    lli_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/line_line_intersection.sv]
// Channel   Direction  Payload
// i_in      sink       two points of line A, two of line B, signed Q16.16
// o_out     source     crossing point, no_crossing, clipped
//
// One transfer in per cycle while the output side keeps taking results.
// A result passes through six front-end stages (differences, products,
// determinant, numerators, magnitudes), a range check and 32 divider stages
// of one quotient bit each, then the output register.
// Reset clears only the valid bits; payload registers load freely.
// On a stall of o_out the whole pipeline holds, so nothing is lost or repeated.
module line_line_intersection (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lli_in_if.sink    i_in,
    lli_out_if.source o_out
);
    import lli_pkg::*;

    logic                r_out_valid;
    t_out_item           r_out_data;
    t_out_item           n_out_data;
    logic [PIPE_LAT-1:0] r_vld;
    logic [DIV_LAT-1:0]  r_zero;
    logic                en;

    t_geom               geom;
    t_coord              coord_x, coord_y;
    logic                clip_x, clip_y;

    // Advance the pipeline whenever the output register is free or drains
    assign en         = ~r_out_valid | o_out.ready;
    assign i_in.ready = en;

    lli_geom u_geom (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (i_in.data),
        .o_geom (geom)
    );

    lli_div u_div_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mag   (geom.mag_x),
        .i_den   (geom.den),
        .i_neg   (geom.neg_x),
        .o_coord (coord_x),
        .o_clip  (clip_x)
    );

    lli_div u_div_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_mag   (geom.mag_y),
        .i_den   (geom.den),
        .i_neg   (geom.neg_y),
        .o_coord (coord_y),
        .o_clip  (clip_y)
    );

    // Zero determinant overrides whatever the divider made of it
    always_comb begin
        if (r_zero[DIV_LAT-1]) begin
            n_out_data.cross_x     = '0;
            n_out_data.cross_y     = '0;
            n_out_data.no_crossing = 1'b1;
            n_out_data.clipped     = 1'b0;
        end else begin
            n_out_data.cross_x     = coord_x;
            n_out_data.cross_y     = coord_y;
            n_out_data.no_crossing = 1'b0;
            n_out_data.clipped     = clip_x | clip_y;
        end
    end

    // Valid bits move in step with the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_vld       <= {r_vld[PIPE_LAT-2:0], i_in.valid};
            r_out_valid <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero     <= {r_zero[DIV_LAT-2:0], geom.zero};
            r_out_data <= n_out_data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    a_parallel_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data.no_crossing |->
            r_out_data.cross_x == '0 && r_out_data.cross_y == '0 && !r_out_data.clipped)
        else $error("no_crossing result carries non-zero fields");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld) && $stable(r_out_data))
        else $error("pipeline moved during an output stall");

    a_valid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[PIPE_LAT-1]))
        else $error("output valid without an item at the last stage");

endmodule

[hdl/lli_geom.sv]
module lli_geom (
    input  logic              i_clk,
    input  logic              i_en,
    input  lli_pkg::t_in_item i_item,
    output lli_pkg::t_geom    o_geom
);
    import lli_pkg::*;

    logic signed [DIFF_W-1:0]  r1_adx, r1_ady, r1_bdx, r1_bdy;
    logic signed [PROD_W-1:0]  r1_pa0, r1_pa1, r1_pb0, r1_pb1;

    logic signed [DIFF_W-1:0]  r2_adx, r2_ady, r2_bdx, r2_bdy;
    logic signed [DPROD_W-1:0] r2_dp0, r2_dp1;
    logic signed [CROSS_W-1:0] r2_pa, r2_pb;

    logic signed [DIFF_W-1:0]  pa_hi, pa_lo, pb_hi, pb_lo;

    logic signed [DET_W-1:0]   r3_det;
    logic signed [DPROD_W-1:0] r3_xah, r3_xal, r3_xbh, r3_xbl;
    logic signed [DPROD_W-1:0] r3_yah, r3_yal, r3_ybh, r3_ybl;

    logic signed [DET_W-1:0]   r4_xh, r4_xl, r4_yh, r4_yl;
    logic        [DET_W-1:0]   r4_den;
    logic                      r4_dneg, r4_zero;

    logic signed [NUM_W-1:0]   r5_nx, r5_ny;
    logic        [DET_W-1:0]   r5_den;
    logic                      r5_dneg, r5_zero;

    t_geom                     r6_geom;

    // Split PA and PB into a signed high part and an unsigned low part
    assign pa_hi = $signed(r2_pa[CROSS_W-1:HALF_W]);
    assign pa_lo = $signed({1'b0, r2_pa[HALF_W-1:0]});
    assign pb_hi = $signed(r2_pb[CROSS_W-1:HALF_W]);
    assign pb_lo = $signed({1'b0, r2_pb[HALF_W-1:0]});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // differences and point cross products
            r1_adx <= DIFF_W'(i_item.a_start_x) - DIFF_W'(i_item.a_end_x);
            r1_ady <= DIFF_W'(i_item.a_start_y) - DIFF_W'(i_item.a_end_y);
            r1_bdx <= DIFF_W'(i_item.b_start_x) - DIFF_W'(i_item.b_end_x);
            r1_bdy <= DIFF_W'(i_item.b_start_y) - DIFF_W'(i_item.b_end_y);
            r1_pa0 <= i_item.a_start_x * i_item.a_end_y;
            r1_pa1 <= i_item.a_start_y * i_item.a_end_x;
            r1_pb0 <= i_item.b_start_x * i_item.b_end_y;
            r1_pb1 <= i_item.b_start_y * i_item.b_end_x;

            // determinant products, PA and PB
            r2_adx <= r1_adx;
            r2_ady <= r1_ady;
            r2_bdx <= r1_bdx;
            r2_bdy <= r1_bdy;
            r2_dp0 <= r1_adx * r1_bdy;
            r2_dp1 <= r1_ady * r1_bdx;
            r2_pa  <= CROSS_W'(r1_pa0) - CROSS_W'(r1_pa1);
            r2_pb  <= CROSS_W'(r1_pb0) - CROSS_W'(r1_pb1);

            // determinant and numerator partial products
            r3_det <= DET_W'(r2_dp0) - DET_W'(r2_dp1);
            r3_xah <= pa_hi * r2_bdx;
            r3_xal <= pa_lo * r2_bdx;
            r3_xbh <= pb_hi * r2_adx;
            r3_xbl <= pb_lo * r2_adx;
            r3_yah <= pa_hi * r2_bdy;
            r3_yal <= pa_lo * r2_bdy;
            r3_ybh <= pb_hi * r2_ady;
            r3_ybl <= pb_lo * r2_ady;

            r4_xh   <= DET_W'(r3_xah) - DET_W'(r3_xbh);
            r4_xl   <= DET_W'(r3_xal) - DET_W'(r3_xbl);
            r4_yh   <= DET_W'(r3_yah) - DET_W'(r3_ybh);
            r4_yl   <= DET_W'(r3_yal) - DET_W'(r3_ybl);
            r4_den  <= r3_det[DET_W-1] ? DET_W'(-r3_det) : DET_W'(r3_det);
            r4_dneg <= r3_det[DET_W-1];
            r4_zero <= (r3_det == '0);

            // recombine the halves into full numerators
            r5_nx   <= $signed({r4_xh, {HALF_W{1'b0}}}) + NUM_W'(r4_xl);
            r5_ny   <= $signed({r4_yh, {HALF_W{1'b0}}}) + NUM_W'(r4_yl);
            r5_den  <= r4_den;
            r5_dneg <= r4_dneg;
            r5_zero <= r4_zero;

            r6_geom.mag_x <= r5_nx[NUM_W-1] ? NUM_W'(-r5_nx) : NUM_W'(r5_nx);
            r6_geom.mag_y <= r5_ny[NUM_W-1] ? NUM_W'(-r5_ny) : NUM_W'(r5_ny);
            r6_geom.neg_x <= r5_nx[NUM_W-1] ^ r5_dneg;
            r6_geom.neg_y <= r5_ny[NUM_W-1] ^ r5_dneg;
            r6_geom.den   <= r5_den;
            r6_geom.zero  <= r5_zero;
        end
    end

    assign o_geom = r6_geom;

endmodule

[hdl/lli_div.sv]
module lli_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [lli_pkg::NUM_W-1:0] i_mag,
    input  logic [lli_pkg::DET_W-1:0] i_den,
    input  logic                      i_neg,
    output lli_pkg::t_coord           o_coord,
    output logic                      o_clip
);
    import lli_pkg::*;

    logic [DET_W-1:0]  r_rem [0:QUOT_W];
    logic [QUOT_W-1:0] r_low [0:QUOT_W];
    logic [DET_W-1:0]  r_den [0:QUOT_W];
    logic [QUOT_W-1:0] r_q   [0:QUOT_W];
    logic              r_neg [0:QUOT_W];
    logic              r_ovf [0:QUOT_W];

    logic [QUOT_W-1:0] quot;

    // Range check: a quotient of 2^32 or more always saturates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_mag[NUM_W-1:QUOT_W];
            r_low[0] <= i_mag[QUOT_W-1:0];
            r_ovf[0] <= (i_mag[NUM_W-1:QUOT_W] >= i_den);
            r_den[0] <= i_den;
            r_neg[0] <= i_neg;
            r_q[0]   <= '0;
        end
    end

    // One restoring step per stage, most significant quotient bit first
    for (genvar k = 0; k < QUOT_W; k++) begin : g_step
        logic [DET_W:0] trial;
        logic           take;

        assign trial = {r_rem[k], r_low[k][QUOT_W-1-k]};
        assign take  = (trial >= {1'b0, r_den[k]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= take ? DET_W'(trial - {1'b0, r_den[k]}) : DET_W'(trial);
                r_q[k+1]   <= {r_q[k][QUOT_W-2:0], take};
                r_low[k+1] <= r_low[k];
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
                r_ovf[k+1] <= r_ovf[k];
            end
        end
    end

    assign quot = r_q[QUOT_W];

    always_comb begin
        if (r_neg[QUOT_W]) begin
            o_clip  = r_ovf[QUOT_W] || (quot > QUOT_W'(COORD_MIN));
            o_coord = o_clip ? COORD_MIN : t_coord'(-quot);
        end else begin
            o_clip  = r_ovf[QUOT_W] || quot[QUOT_W-1];
            o_coord = o_clip ? COORD_MAX : t_coord'(quot);
        end
    end

endmodule
